// ===== sv/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the literal substring replace stream.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Byte slots in a window snapshot or a replacement string
    localparam int SLOTS  = 16;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 64;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_PATTERN_LO  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PATTERN_HI  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PATTERN_LEN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REPLACE_LO  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REPLACE_HI  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_REPLACE_LEN = 3'd5;
    localparam logic [IDX_W-1:0] CFG_GLOBAL_MODE = 3'd6;

    // One emit command: send the first n bytes of data, byte 0 first.
    // n of zero with last set sends one marker result that carries no byte.
    typedef struct packed {
        logic [SLOTS*BYTE_W-1:0] data;
        logic [LEN_W-1:0]        n;
        logic                    last;
    } cmd_t;

endpackage

// ===== sv/literal_substring_replace_stream.sv =====
// ----------------------------------------------------------------------------
// literal_substring_replace_stream
// Streaming literal substitution: replaces a literal pattern with a literal
// replacement in a byte stream, leftmost first and non-overlapping.
// ----------------------------------------------------------------------------
// The block accepts one byte per cycle and emits one result byte per cycle
// when not stalled. A byte that completes a non-matching window yields one
// result, a match yields replace_len results, and a newline or the final
// byte flushes the held window, so one input can produce up to 16 results.
// The output side is paced by the byte emitter at one result per cycle
// while m_tready is high; a two-entry command queue between classifier and
// emitter lets the input keep flowing while a result waits, and the input
// stalls only when that queue is full. Configuration must be written while
// the stream is idle; the block does not enforce this. Writing pattern_len
// discards any held bytes.
// ----------------------------------------------------------------------------
module literal_substring_replace_stream #(
    parameter int PATTERN_MAX = 16,
    parameter int REPLACE_MAX = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wen,
    input  logic [lss_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lss_pkg::CFG_W-1:0]  cfg_wdata,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] in_byte
    input  logic                       s_tlast,   // in_last
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,   // out_last
    output logic [1:0]                 m_tuser    // [0] out_valid_byte, [1] out_stream_end
);
    import lss_pkg::*;

    logic s_fire;
    logic push;
    cmd_t push_cmd;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign s_fire = s_tvalid && s_tready;

    // Classify input bytes
    lss_front #(
        .PATTERN_MAX(PATTERN_MAX),
        .REPLACE_MAX(REPLACE_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_fire   (s_fire),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue emit commands
    lss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_ready(s_tready),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    // Emit result bytes
    lss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_valid),
        .cmd      (q_cmd),
        .cmd_pop  (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front
// Holds configuration and the match window, classifies each input byte and
// issues emit commands to the queue.
// ----------------------------------------------------------------------------
module lss_front #(
    parameter int PATTERN_MAX = 16,
    parameter int REPLACE_MAX = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [lss_pkg::IDX_W-1:0]     cfg_index,
    input  logic [lss_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_fire,
    input  logic [lss_pkg::BYTE_W-1:0]    s_byte,
    input  logic                          s_last,
    output logic                          push,
    output lss_pkg::cmd_t                 push_cmd
);
    import lss_pkg::*;

    localparam int WIN  = (PATTERN_MAX < SLOTS) ? PATTERN_MAX : SLOTS;
    localparam int RMAX = (REPLACE_MAX < SLOTS) ? REPLACE_MAX : SLOTS;
    localparam int RST  = (RMAX < 1) ? 1 : RMAX;
    localparam logic [LEN_W-1:0] WIN_LEN  = LEN_W'(WIN);
    localparam logic [LEN_W-1:0] RMAX_LEN = LEN_W'(RMAX);

    logic [BYTE_W-1:0] pat_reg [WIN];
    logic [BYTE_W-1:0] rep_reg [RST];
    logic [BYTE_W-1:0] win_reg [WIN];
    logic [LEN_W-1:0]  plen_cfg_reg;
    logic [LEN_W-1:0]  rlen_cfg_reg;
    logic              gmode_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic              line_rep_reg;
    logic              line_rep_next;

    logic [BYTE_W-1:0]       win_app [SLOTS];
    logic [SLOTS*BYTE_W-1:0] win_vec;
    logic [SLOTS*BYTE_W-1:0] rep_vec;
    logic [SLOTS-1:0]        match_bits;
    logic [LEN_W-1:0]        plen;
    logic [LEN_W-1:0]        rlen;
    logic [LEN_W-1:0]        cnt1;
    logic                    flush_line;
    logic                    full;
    logic                    hit;
    logic                    nl;
    logic                    shift;

    // Pattern bytes, one register per byte
    genvar g;
    for (g = 0; g < WIN; g++) begin : g_pat
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pat_reg[g] <= '0;
            end else if (cfg_wen) begin
                if (g < 8 && cfg_index == CFG_PATTERN_LO) begin
                    pat_reg[g] <= cfg_wdata[BYTE_W*(g & 7) +: BYTE_W];
                end else if (g >= 8 && cfg_index == CFG_PATTERN_HI) begin
                    pat_reg[g] <= cfg_wdata[BYTE_W*(g & 7) +: BYTE_W];
                end
            end
        end
    end

    // Replacement bytes
    for (g = 0; g < RST; g++) begin : g_rep
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rep_reg[g] <= '0;
            end else if (cfg_wen) begin
                if (g < 8 && cfg_index == CFG_REPLACE_LO) begin
                    rep_reg[g] <= cfg_wdata[BYTE_W*(g & 7) +: BYTE_W];
                end else if (g >= 8 && cfg_index == CFG_REPLACE_HI) begin
                    rep_reg[g] <= cfg_wdata[BYTE_W*(g & 7) +: BYTE_W];
                end
            end
        end
    end

    // Scalar configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_cfg_reg <= LEN_W'(1);
            rlen_cfg_reg <= '0;
            gmode_reg    <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_PATTERN_LEN: plen_cfg_reg <= cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_LEN: rlen_cfg_reg <= cfg_wdata[LEN_W-1:0];
                CFG_GLOBAL_MODE: gmode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Window with the new byte appended at the fill position
    for (g = 0; g < SLOTS; g++) begin : g_app
        if (g < WIN) begin : g_in
            assign win_app[g]    = (count_reg == LEN_W'(g)) ? s_byte : win_reg[g];
            assign match_bits[g] = (LEN_W'(g) >= plen) || (win_app[g] == pat_reg[g]);
        end else begin : g_out
            assign win_app[g]    = '0;
            assign match_bits[g] = 1'b1;
        end
        assign win_vec[BYTE_W*g +: BYTE_W] = win_app[g];
        if (g < RMAX) begin : g_rv
            assign rep_vec[BYTE_W*g +: BYTE_W] = rep_reg[g];
        end else begin : g_rz
            assign rep_vec[BYTE_W*g +: BYTE_W] = '0;
        end
    end

    // Saturate the configured lengths
    always_comb begin
        if (plen_cfg_reg == '0) begin
            plen = LEN_W'(1);
        end else if (plen_cfg_reg > WIN_LEN) begin
            plen = WIN_LEN;
        end else begin
            plen = plen_cfg_reg;
        end
        rlen = (rlen_cfg_reg > RMAX_LEN) ? RMAX_LEN : rlen_cfg_reg;
    end

    // Classify the byte and build the emit command
    always_comb begin
        cnt1          = count_reg + LEN_W'(1);
        flush_line    = line_rep_reg && !gmode_reg;
        full          = (cnt1 == plen);
        hit           = full && (&match_bits);
        nl            = (s_byte == NEWLINE) || s_last;
        push_cmd.data = win_vec;
        push_cmd.n    = '0;
        push_cmd.last = s_last;
        shift         = 1'b0;
        count_next    = cnt1;
        line_rep_next = line_rep_reg;
        priority if (flush_line) begin
            push_cmd.n = cnt1;
            count_next = '0;
        end else if (hit) begin
            push_cmd.data = rep_vec;
            push_cmd.n    = rlen;
            count_next    = '0;
            line_rep_next = 1'b1;
        end else if (full) begin
            if (nl) begin
                push_cmd.n = cnt1;
                count_next = '0;
            end else begin
                push_cmd.n = LEN_W'(1);
                shift      = 1'b1;
                count_next = count_reg;
            end
        end else if (nl) begin
            push_cmd.n = cnt1;
            count_next = '0;
        end
        if (nl) begin
            line_rep_next = 1'b0;
        end
        push = s_fire && ((push_cmd.n != '0) || s_last);
    end

    // Window storage: shift out the oldest byte on a miss, else append
    for (g = 0; g < WIN; g++) begin : g_win
        logic [BYTE_W-1:0] up;
        if (g < WIN - 1) begin : g_up
            assign up = win_app[g+1];
        end else begin : g_top
            assign up = win_app[g];
        end
        always_ff @(posedge aclk) begin
            if (s_fire) begin
                win_reg[g] <= shift ? up : win_app[g];
            end
        end
    end

    // Fill count and per-line flag; a pattern length write drops held bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            line_rep_reg <= 1'b0;
        end else if (cfg_wen && cfg_index == CFG_PATTERN_LEN) begin
            count_reg <= '0;
        end else if (s_fire) begin
            count_reg    <= count_next;
            line_rep_reg <= line_rep_next;
        end
    end

endmodule

// ===== sv/lss_fifo.sv =====
// ----------------------------------------------------------------------------
// lss_fifo
// Short command queue that decouples the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module lss_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lss_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output lss_pkg::cmd_t pop_cmd
);
    import lss_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (cnt_reg != CW'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Store the incoming command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ===== sv/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back
// Byte emitter: expands one command into result items, one per cycle unless m_tready stalls.
// ----------------------------------------------------------------------------
module lss_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    input  lss_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lss_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);
    import lss_pkg::*;

    logic                    valid_reg;
    logic [SLOTS*BYTE_W-1:0] data_reg;
    logic [LEN_W-1:0]        rem_reg;
    logic                    last_reg;
    logic                    final_beat;
    logic                    done;

    assign final_beat = (rem_reg <= LEN_W'(1));
    assign done       = !valid_reg || (m_tready && final_beat);
    assign cmd_pop    = done && cmd_valid;

    // Drive the current result; a marker carries a zero byte
    assign m_tvalid   = valid_reg;
    assign m_tdata    = (rem_reg == '0) ? '0 : data_reg[BYTE_W-1:0];
    assign m_tlast    = final_beat;
    assign m_tuser[0] = (rem_reg != '0);
    assign m_tuser[1] = last_reg && final_beat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (done) begin
            valid_reg <= cmd_valid;
        end
    end

    // Load the next command or shift to the next byte
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            data_reg <= cmd.data;
            rem_reg  <= cmd.n;
            last_reg <= cmd.last;
        end else if (valid_reg && m_tready && !final_beat) begin
            data_reg <= data_reg >> BYTE_W;
            rem_reg  <= rem_reg - LEN_W'(1);
        end
    end

endmodule
